>>> rtl/bmrg_pkg.sv
package bmrg_pkg;

    localparam int MEM_WORDS_DEF = 16384;

    localparam int KIND_W   = 3;
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 32;
    localparam int LIMIT_W  = 17;
    localparam int CFG_IDX_W = 1;

    localparam logic [KIND_W-1:0] KIND_RD_BYTE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RD_HALF  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RD_WORD  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WR_BYTE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_WR_HALF  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_WR_WORD  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_FETCH    = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNUSED   = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_ROM_PROTECT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_LIMIT   = 1'b1;

    // low two bits of the first instruction byte marking a 32-bit instruction
    localparam logic [1:0] LOW_CODE_MASK = 2'b11;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              instr_is_32bit;
        logic              write_blocked;
    } rsp_t;

endpackage

>>> rtl/bmrg_addr_unit.sv
module bmrg_addr_unit #(
    parameter int UW = 18
) (
    input  logic [UW-1:0] a,
    input  logic [UW-1:0] b,
    input  logic          inc,
    output logic [UW-1:0] res,
    output logic          ge
);
    logic [UW-1:0] sum;
    logic [UW:0]   diff;

    // add the increment, then subtract b when the sum reaches it
    always_comb
    begin
        sum  = a + UW'(inc);
        diff = {1'b0, sum} - {1'b0, b};
        ge   = ~diff[UW];
        res  = ge ? diff[UW-1:0] : sum;
    end

endmodule

>>> rtl/bmrg_byte_ram.sv
module bmrg_byte_ram #(
    parameter int MEM_BYTES = 65536,
    parameter int AW        = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);
    logic [7:0] mem [0:MEM_BYTES-1];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/byte_memory_with_rom_guard.sv
// Byte-addressed little-endian memory with a write guard over a read-only
// image. Pulse start while busy is low to hand in one access; busy stays high
// until done pulses for exactly one cycle with the result, which must be taken
// then: the receiver cannot hold it off. All bytes go through one single-port
// byte RAM, one byte per pass, and one shared add/compare unit wraps addresses
// and checks the guard. The unused kind goes straight to done; any other
// access first wraps its start address into the RAM (skipped at the default
// size), then a write checks the guard and writes its bytes or, if blocked,
// goes to done, while a read or fetch issues and captures each byte in turn.
// The next access is taken the cycle after done. The RAM needs no clearing.
module byte_memory_with_rom_guard #(
    parameter int MEM_WORDS = bmrg_pkg::MEM_WORDS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  bmrg_pkg::req_t                        req,
    output logic                                  done,
    output bmrg_pkg::rsp_t                        rsp,
    input  logic                                  cfg_write,
    input  logic [bmrg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bmrg_pkg::LIMIT_W-1:0]          cfg_data
);
    import bmrg_pkg::*;

    localparam int MEM_BYTES = MEM_WORDS * 4;
    localparam int AW        = $clog2(MEM_BYTES);
    localparam int UW        = ((AW > LIMIT_W) ? AW : LIMIT_W) + 1;
    localparam int RED_STEPS = $clog2((65536 + MEM_BYTES - 1) / MEM_BYTES);
    localparam int RC_W      = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
    localparam logic [RC_W-1:0] RED_INIT = (RED_STEPS > 0) ? RC_W'(RED_STEPS - 1) : '0;
    localparam logic [UW-1:0]   MEM_BYTES_U = UW'(MEM_BYTES);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_REDUCE   = 3'd1;
    localparam logic [2:0] S_GUARD    = 3'd2;
    localparam logic [2:0] S_WRITE    = 3'd3;
    localparam logic [2:0] S_RD_ISSUE = 3'd4;
    localparam logic [2:0] S_RD_CAPT  = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [UW-1:0]      addr_reg, addr_next;
    logic [DATA_W-1:0]  data_reg, data_next;
    logic [1:0]         idx_reg, idx_next;
    logic [1:0]         last_reg, last_next;
    logic [RC_W-1:0]    red_reg, red_next;
    logic [DATA_W-1:0]  rbuf_reg, rbuf_next;
    logic               is32_reg, is32_next;
    logic               blocked_reg, blocked_next;

    logic                rom_protect_reg;
    logic [LIMIT_W-1:0]  rom_limit_reg;

    logic [UW-1:0] unit_a, unit_b, unit_res;
    logic          unit_inc, unit_ge;

    logic          ram_we;
    logic [7:0]    ram_rdata;

    function automatic logic [2:0] dispatch(input logic [KIND_W-1:0] k);
        logic [2:0] s;
        case (k) inside
            KIND_WR_BYTE, KIND_WR_HALF, KIND_WR_WORD: s = S_GUARD;
            default:                                  s = S_RD_ISSUE;
        endcase
        return s;
    endfunction

    function automatic logic [1:0] last_of(input logic [KIND_W-1:0] k);
        logic [1:0] n;
        case (k) inside
            KIND_RD_HALF, KIND_WR_HALF, KIND_FETCH: n = 2'd1;
            KIND_RD_WORD, KIND_WR_WORD:             n = 2'd3;
            default:                                n = 2'd0;
        endcase
        return n;
    endfunction

    bmrg_addr_unit #(
        .UW (UW)
    ) u_unit (
        .a   (unit_a),
        .b   (unit_b),
        .inc (unit_inc),
        .res (unit_res),
        .ge  (unit_ge)
    );

    bmrg_byte_ram #(
        .MEM_BYTES (MEM_BYTES),
        .AW        (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (addr_reg[AW-1:0]),
        .wdata (data_reg[7:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_protect_reg <= 1'b0;
            rom_limit_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ROM_PROTECT: rom_protect_reg <= cfg_data[0];
                CFG_ROM_LIMIT:   rom_limit_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unit_a   = addr_reg;
        unit_b   = MEM_BYTES_U;
        unit_inc = 1'b1;
        unique case (state_reg)
            S_REDUCE:
            begin
                unit_b   = MEM_BYTES_U << red_reg;
                unit_inc = 1'b0;
            end
            S_GUARD:
            begin
                unit_b   = UW'(rom_limit_reg);
                unit_inc = 1'b0;
            end
            default: ;
        endcase
    end

    assign ram_we = (state_reg == S_WRITE);

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        addr_next    = addr_reg;
        data_next    = data_reg;
        idx_next     = idx_reg;
        last_next    = last_reg;
        red_next     = red_reg;
        rbuf_next    = rbuf_reg;
        is32_next    = is32_reg;
        blocked_next = blocked_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next    = req.kind;
                    addr_next    = UW'(req.address);
                    data_next    = req.write_data;
                    idx_next     = 2'd0;
                    last_next    = last_of(req.kind);
                    red_next     = RED_INIT;
                    rbuf_next    = '0;
                    is32_next    = 1'b0;
                    blocked_next = 1'b0;
                    if (req.kind == KIND_UNUSED)
                        state_next = S_DONE;
                    else if (RED_STEPS > 0)
                        state_next = S_REDUCE;
                    else
                        state_next = dispatch(req.kind);
                end
            end
            S_REDUCE:
            begin
                // subtract the shifted memory size when it fits
                addr_next = unit_res;
                if (red_reg == '0)
                    state_next = dispatch(kind_reg);
                else
                    red_next = red_reg - 1'b1;
            end
            S_GUARD:
            begin
                if (rom_protect_reg && !unit_ge)
                begin
                    blocked_next = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                data_next = data_reg >> 8;
                addr_next = unit_res;
                if (idx_reg == last_reg)
                    state_next = S_DONE;
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_RD_ISSUE:
            begin
                addr_next  = unit_res;
                state_next = S_RD_CAPT;
            end
            S_RD_CAPT:
            begin
                rbuf_next[idx_reg*8 +: 8] = ram_rdata;
                // widen a fetch to four bytes on a 32-bit opcode
                if (idx_reg == 2'd0 && kind_reg == KIND_FETCH
                    && (ram_rdata[1:0] & LOW_CODE_MASK) == LOW_CODE_MASK)
                begin
                    last_next = 2'd3;
                    is32_next = 1'b1;
                end
                if (idx_reg == last_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_RD_ISSUE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        addr_reg    <= addr_next;
        data_reg    <= data_next;
        idx_reg     <= idx_next;
        last_reg    <= last_next;
        red_reg     <= red_next;
        rbuf_reg    <= rbuf_next;
        is32_reg    <= is32_next;
        blocked_reg <= blocked_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    always_comb
    begin
        rsp.read_data      = rbuf_reg;
        rsp.instr_is_32bit = is32_reg;
        rsp.write_blocked  = blocked_reg;
    end

endmodule

>>> bench/byte_memory_with_rom_guard_check.sv
module byte_memory_with_rom_guard_check (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  bmrg_pkg::req_t                 req,
    input  logic                           done,
    input  bmrg_pkg::rsp_t                 rsp,
    input  logic                           cfg_write,
    input  logic [bmrg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bmrg_pkg::LIMIT_W-1:0]   cfg_data,
    output int unsigned                    mismatch_count,
    output int unsigned                    pending_count
);
    import bmrg_pkg::*;

    localparam int unsigned MEM_BYTES = 4 * MEM_WORDS_DEF;

    logic [7:0]         mem_image [MEM_BYTES];
    logic               guard_on;
    logic [LIMIT_W-1:0] guard_limit;
    rsp_t               expected_rsp_q [$];
    int unsigned        errors;

    function automatic logic [DATA_W-1:0] load_le(int unsigned base, int unsigned count);
        logic [DATA_W-1:0] v;
        v = '0;
        for (int i = 0; i < count; i++)
        begin
            v[8*i +: 8] = mem_image[(base + i) % MEM_BYTES];
        end
        return v;
    endfunction

    // only the start address is checked against the guard
    function automatic logic store_le(int unsigned base, logic [DATA_W-1:0] data,
                                      int unsigned count);
        if (guard_on && base < guard_limit)
        begin
            return 1'b1;
        end
        for (int i = 0; i < count; i++)
        begin
            mem_image[(base + i) % MEM_BYTES] = data[8*i +: 8];
        end
        return 1'b0;
    endfunction

    function automatic rsp_t predict_access(req_t r);
        rsp_t        p;
        int unsigned base;
        p    = '0;
        base = r.address % MEM_BYTES;
        case (r.kind)
            KIND_RD_BYTE: p.read_data = load_le(base, 1);
            KIND_RD_HALF: p.read_data = load_le(base, 2);
            KIND_RD_WORD: p.read_data = load_le(base, 4);
            KIND_WR_BYTE: p.write_blocked = store_le(base, r.write_data, 1);
            KIND_WR_HALF: p.write_blocked = store_le(base, r.write_data, 2);
            KIND_WR_WORD: p.write_blocked = store_le(base, r.write_data, 4);
            KIND_FETCH:
            begin
                if ((mem_image[base][1:0] & LOW_CODE_MASK) == LOW_CODE_MASK)
                begin
                    p.instr_is_32bit = 1'b1;
                    p.read_data      = load_le(base, 4);
                end
                else
                begin
                    p.read_data = load_le(base, 2);
                end
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic flag(string what, logic [DATA_W-1:0] want_v, logic [DATA_W-1:0] got_v);
        errors++;
        if (errors <= 10)
        begin
            $display("%0t: %s expected %h got %h", $time, what, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            guard_on    = 1'b0;
            guard_limit = '0;
            errors      = 0;
            expected_rsp_q.delete();
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_ROM_PROTECT)
                begin
                    guard_on = cfg_data[0];
                end
                else
                begin
                    guard_limit = cfg_data;
                end
            end
            if (done)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    flag("word with none pending, read_data", '0, rsp.read_data);
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.read_data !== want.read_data)
                    begin
                        flag("read_data", want.read_data, rsp.read_data);
                    end
                    if (rsp.instr_is_32bit !== want.instr_is_32bit)
                    begin
                        flag("instr_is_32bit", DATA_W'(want.instr_is_32bit),
                             DATA_W'(rsp.instr_is_32bit));
                    end
                    if (rsp.write_blocked !== want.write_blocked)
                    begin
                        flag("write_blocked", DATA_W'(want.write_blocked),
                             DATA_W'(rsp.write_blocked));
                    end
                end
            end
            if (start && !busy)
            begin
                expected_rsp_q.push_back(predict_access(req));
            end
            mismatch_count <= errors;
            pending_count  <= expected_rsp_q.size();
        end
    end

endmodule

>>> bench/byte_memory_with_rom_guard_tb.sv
module byte_memory_with_rom_guard_tb;
    import bmrg_pkg::*;

    localparam int unsigned MEM_BYTES   = 4 * MEM_WORDS_DEF;
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    req_t                 req;
    logic                 done;
    rsp_t                 rsp;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LIMIT_W-1:0]   cfg_data;
    int unsigned          mismatch_count;
    int unsigned          pending_count;
    int unsigned          cycle_count;

    // bytes known to hold data; reads never touch anything else
    bit                   written [MEM_BYTES];
    bit                   prot_shadow;
    int unsigned          limit_shadow;
    bit                   steady;

    byte_memory_with_rom_guard u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    byte_memory_with_rom_guard_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req            (req),
        .done           (done),
        .rsp            (rsp),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int unsigned span_of(logic [KIND_W-1:0] k);
        if (k == KIND_RD_BYTE || k == KIND_WR_BYTE)
        begin
            return 1;
        end
        if (k == KIND_RD_HALF || k == KIND_WR_HALF)
        begin
            return 2;
        end
        return 4;
    endfunction

    function automatic bit span_written(int unsigned base, int unsigned count);
        for (int i = 0; i < count; i++)
        begin
            if (!written[(base + i) % MEM_BYTES])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // hot windows: bottom, top with wrap, the bit-15 boundary and the guard edge, plus any address
    function automatic logic [ADDR_W-1:0] pick_addr();
        case ($urandom_range(4))
            0:       return ADDR_W'($urandom_range(16'h003F));
            1:       return ADDR_W'(16'hFFC0 + $urandom_range(16'h003F));
            2:       return ADDR_W'(16'h7FE0 + $urandom_range(16'h003F));
            3:       return ADDR_W'(limit_shadow - 4 + $urandom_range(7));
            default: return ADDR_W'($urandom());
        endcase
    endfunction

    task automatic issue(logic [KIND_W-1:0] k, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
        bit is_write;
        is_write = (k == KIND_WR_BYTE || k == KIND_WR_HALF || k == KIND_WR_WORD);
        if (!steady && $urandom_range(99) < 30)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        req   <= '{kind: k, address: a, write_data: d};
        start <= 1'b1;
        do @(posedge clk); while (busy);
        if (is_write && !(prot_shadow && a < limit_shadow))
        begin
            for (int i = 0; i < span_of(k); i++)
            begin
                written[(a + i) % MEM_BYTES] = 1'b1;
            end
        end
    endtask

    // hold off until every expected word is back
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (busy || pending_count != 0);
    endtask

    task automatic set_guard(bit on, int unsigned limit);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= CFG_ROM_PROTECT;
        cfg_data  <= LIMIT_W'(on);
        @(posedge clk);
        cfg_index <= CFG_ROM_LIMIT;
        cfg_data  <= LIMIT_W'(limit);
        @(posedge clk);
        cfg_write    <= 1'b0;
        prot_shadow  = on;
        limit_shadow = limit;
    endtask

    task automatic random_burst(int unsigned count);
        int unsigned      issued;
        int unsigned      roll;
        logic [KIND_W-1:0] k;
        logic [ADDR_W-1:0] a;
        issued = 0;
        while (issued < count)
        begin
            roll = $urandom_range(99);
            a    = pick_addr();
            if (roll < 40)
            begin
                k = KIND_W'(KIND_WR_BYTE + $urandom_range(2));
            end
            else if (roll < 75)
            begin
                k = KIND_W'(KIND_RD_BYTE + $urandom_range(2));
            end
            else if (roll < 95)
            begin
                k = KIND_FETCH;
            end
            else
            begin
                k = KIND_UNUSED;
            end
            // fill the span first where it holds no data yet
            if ((k == KIND_RD_BYTE || k == KIND_RD_HALF || k == KIND_RD_WORD ||
                 k == KIND_FETCH) && !span_written(a, span_of(k)))
            begin
                k = KIND_WR_WORD;
            end
            if ($urandom_range(99) < 2)
            begin
                drain();
            end
            issue(k, a, $urandom());
            if (k != KIND_UNUSED)
            begin
                issued++;
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        req          = '0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        prot_shadow  = 1'b0;
        limit_shadow = 0;
        steady       = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        set_guard(1'b0, 17'h10000);
        issue(KIND_WR_WORD, 16'h0000, 32'h0302_0113);
        issue(KIND_WR_WORD, 16'h0004, 32'h1234_5678);
        issue(KIND_WR_WORD, 16'hFFFC, 32'hFFFF_FFFF);
        issue(KIND_WR_HALF, 16'hFFFF, 32'hFFFF_A5C3);
        issue(KIND_WR_BYTE, 16'h8000, 32'hFFFF_FF80);
        issue(KIND_WR_WORD, 16'h7FFC, 32'h0000_0000);
        issue(KIND_RD_BYTE, 16'h8000, 32'h0000_0000);
        issue(KIND_RD_HALF, 16'h7FFF, 32'hFFFF_FFFF);
        issue(KIND_RD_HALF, 16'hFFFF, 32'h0000_0000);
        issue(KIND_RD_WORD, 16'hFFFE, 32'h0000_0000);
        issue(KIND_RD_WORD, 16'h0001, 32'h0000_0000);
        issue(KIND_FETCH,   16'h0004, 32'h0000_0000);
        issue(KIND_FETCH,   16'h0000, 32'h0000_0000);
        issue(KIND_FETCH,   16'hFFFF, 32'h0000_0000);
        issue(KIND_UNUSED,  16'h5A5A, 32'hFFFF_FFFF);
        random_burst(120);

        set_guard(1'b1, 17'h00040);
        issue(KIND_WR_WORD, 16'h003F, 32'h1111_1111);
        issue(KIND_WR_BYTE, 16'h0040, 32'h0000_00AA);
        issue(KIND_WR_HALF, 16'h0000, 32'h0000_5555);
        // start above the limit: the wrapped tail lands in the image anyway
        issue(KIND_WR_WORD, 16'hFFFE, 32'h8765_4321);
        issue(KIND_RD_WORD, 16'h0000, 32'h0000_0000);
        issue(KIND_RD_BYTE, 16'h0040, 32'h0000_0000);
        random_burst(90);

        set_guard(1'b1, 17'h10000);
        random_burst(50);
        set_guard(1'b1, 17'h0FFFF);
        random_burst(50);

        steady = 1'b1;
        set_guard(1'b1, $urandom_range(1, 16'hFFFE));
        random_burst(70);
        steady = 1'b0;

        set_guard(1'b1, 17'h00000);
        random_burst(50);
        set_guard(1'b0, 17'h00040);
        random_burst(50);

        drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
